// ----- rtl/hise_pkg.sv -----
// ---------------------------------------------------------------------------
// hise_pkg: shared types and constants for the hashed identifier set
// Request and response payloads, action codes and default geometry.
// ---------------------------------------------------------------------------
package hise_pkg;

    localparam int KEY_W       = 64;
    localparam int DEF_BUCKETS = 256;
    localparam int DEF_WAYS    = 4;
    localparam int HASH_W      = 8;

    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key_low;
        logic [KEY_W-1:0] key_high;
    } t_req;

    typedef struct packed {
        logic was_present;
        logic overflow;
    } t_rsp;

endpackage

// ----- rtl/hise_hash.sv -----
// ---------------------------------------------------------------------------
// hise_hash: bucket index of an identifier
// Sums the sixteen key bytes modulo 256 and folds the sum onto the bucket
// count through a constant remainder table.
// ---------------------------------------------------------------------------
module hise_hash #(
    parameter int BUCKETS = hise_pkg::DEF_BUCKETS
) (
    input  logic [hise_pkg::KEY_W-1:0]   i_key_low,
    input  logic [hise_pkg::KEY_W-1:0]   i_key_high,
    output logic [$clog2(BUCKETS)-1:0]   o_bucket
);
    import hise_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int HASH_N = 1 << HASH_W;

    logic [HASH_W-1:0] sum_low;
    logic [HASH_W-1:0] sum_high;
    logic [HASH_W-1:0] hash;
    logic [BW-1:0]     rem_lut [HASH_N];

    // Each half is summed separately; the wrap of the 8-bit adds is the modulo.
    always_comb begin
        sum_low  = '0;
        sum_high = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            sum_low  = sum_low  + i_key_low[b*8 +: 8];
            sum_high = sum_high + i_key_high[b*8 +: 8];
        end
        hash = sum_low + sum_high;
    end

    for (genvar g = 0; g < HASH_N; g++) begin : g_lut
        localparam int REM = g % BUCKETS;
        assign rem_lut[g] = BW'(REM);
    end

    assign o_bucket = rem_lut[hash];

endmodule

// ----- rtl/hise_row_mem.sv -----
// ---------------------------------------------------------------------------
// hise_row_mem: bucket row storage
// One row per bucket, one write port and one read port, registered read.
// ---------------------------------------------------------------------------
module hise_row_mem #(
    parameter int BUCKETS = hise_pkg::DEF_BUCKETS,
    parameter int ROW_W   = hise_pkg::DEF_WAYS * (2 * hise_pkg::KEY_W + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(BUCKETS)-1:0] i_rd_addr,
    output logic [ROW_W-1:0]           o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(BUCKETS)-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]           i_wr_data
);
    import hise_pkg::*;

    logic [ROW_W-1:0] r_mem [BUCKETS];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/hise_match.sv -----
// ---------------------------------------------------------------------------
// hise_match: way compare and update of one bucket row
// Compares the key against all ways at once, picks the lowest free way and
// the lowest hit, and works out the new valid bits and the response.
// ---------------------------------------------------------------------------
module hise_match #(
    parameter int WAYS = hise_pkg::DEF_WAYS
) (
    input  logic [1:0]                    i_action,
    input  logic [2*hise_pkg::KEY_W-1:0]  i_key,
    input  logic [WAYS-1:0]               i_valid,
    input  logic [WAYS*2*hise_pkg::KEY_W-1:0] i_keys,
    output logic                          o_wr_en,
    output logic [WAYS-1:0]               o_valid_next,
    output logic [WAYS-1:0]               o_fill_oh,
    output hise_pkg::t_rsp                o_rsp
);
    import hise_pkg::*;

    localparam int SLOT_W = 2 * KEY_W;

    logic [WAYS-1:0] match;
    logic [WAYS-1:0] free;
    logic [WAYS-1:0] hit_oh;
    logic [WAYS-1:0] free_oh;
    logic            present;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = i_valid[w] && (i_keys[w*SLOT_W +: SLOT_W] == i_key);
        end
        free    = ~i_valid;
        // Lowest set bit of each vector.
        hit_oh  = match & (~match + WAYS'(1));
        free_oh = free & (~free + WAYS'(1));
        present = |match;
    end

    always_comb begin
        o_wr_en          = 1'b0;
        o_valid_next     = i_valid;
        o_fill_oh        = '0;
        o_rsp.was_present = present;
        o_rsp.overflow   = 1'b0;
        unique case (i_action)
            ACT_INSERT: begin
                if (!present) begin
                    if (|free) begin
                        o_wr_en      = 1'b1;
                        o_fill_oh    = free_oh;
                        o_valid_next = i_valid | free_oh;
                    end else begin
                        o_rsp.overflow = 1'b1;
                    end
                end
            end
            ACT_REMOVE: begin
                if (present) begin
                    o_wr_en      = 1'b1;
                    o_valid_next = i_valid & ~hit_oh;
                end
            end
            ACT_QUERY, ACT_CLEAR: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/hashed_id_set_engine.sv -----
// ---------------------------------------------------------------------------
// hashed_id_set_engine: set of 16-byte identifiers in a bucketed table
// Query, insert, remove or clear; each answers whether the identifier was
// present, and inserting an absent one into a full bucket flags overflow.
// ---------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a rising edge with i_start high and
//   o_busy low; the payload i_req carries the action and the two key halves.
//   The request hashes to a bucket whose row is read from a row memory
//   with one read and one write port in the same edge. In the next cycle
//   the ways are compared, the row is written back and the response is
//   registered. o_done is high for exactly one cycle with o_rsp; the
//   receiver cannot stall and must take it then.
//   o_busy is high for the one cycle between read and write back, so no new
//   request is taken until the read-modify-write of one memory row is done.
//   A clear transaction drops all rows at once through per-row valid flags
//   held in flip-flops; the memory itself needs no clearing pass.
//   Reset empties the set immediately and leaves the block idle.
// ---------------------------------------------------------------------------
module hashed_id_set_engine #(
    parameter int BUCKETS = hise_pkg::DEF_BUCKETS,
    parameter int WAYS    = hise_pkg::DEF_WAYS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  hise_pkg::t_req i_req,
    output logic           o_done,
    output hise_pkg::t_rsp o_rsp
);
    import hise_pkg::*;

    localparam int BW     = $clog2(BUCKETS);
    localparam int SLOT_W = 2 * KEY_W;
    localparam int KEYS_W = WAYS * SLOT_W;
    localparam int ROW_W  = KEYS_W + WAYS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_req             r_req;
    logic [BW-1:0]    r_bucket;
    logic [BUCKETS-1:0] r_row_valid;
    logic             r_done;
    t_rsp             r_rsp;

    logic             accept;
    logic [BW-1:0]    bucket;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic [WAYS-1:0]  valid_cur;
    logic             wr_en;
    logic             mem_wr;
    logic [WAYS-1:0]  valid_next;
    logic [WAYS-1:0]  fill_oh;
    t_rsp             rsp;

    assign o_busy = (r_state == ST_LOOK);
    assign accept = i_start && !o_busy;

    hise_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_key_low  (i_req.key_low),
        .i_key_high (i_req.key_high),
        .o_bucket   (bucket)
    );

    hise_row_mem #(
        .BUCKETS (BUCKETS),
        .ROW_W   (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (bucket),
        .o_rd_data (rd_row),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_bucket),
        .i_wr_data (wr_row)
    );

    // A row not touched since the last clear holds no identifiers.
    assign valid_cur = r_row_valid[r_bucket] ? rd_row[KEYS_W +: WAYS] : '0;

    hise_match #(
        .WAYS (WAYS)
    ) u_match (
        .i_action     (r_req.action),
        .i_key        ({r_req.key_high, r_req.key_low}),
        .i_valid      (valid_cur),
        .i_keys       (rd_row[KEYS_W-1:0]),
        .o_wr_en      (wr_en),
        .o_valid_next (valid_next),
        .o_fill_oh    (fill_oh),
        .o_rsp        (rsp)
    );

    assign mem_wr = o_busy && wr_en;

    always_comb begin
        wr_row[KEYS_W +: WAYS] = valid_next;
        for (int w = 0; w < WAYS; w++) begin
            wr_row[w*SLOT_W +: SLOT_W] = fill_oh[w] ? {r_req.key_high, r_req.key_low}
                                                    : rd_row[w*SLOT_W +: SLOT_W];
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = accept ? ST_LOOK : ST_IDLE;
            ST_LOOK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_valid <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_busy;
            if (o_busy) begin
                if (r_req.action == ACT_CLEAR) begin
                    r_row_valid <= '0;
                end else if (wr_en) begin
                    r_row_valid[r_bucket] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req;
            r_bucket <= bucket;
        end
        if (o_busy) begin
            r_rsp <= rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("response did not follow request by two cycles");

    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("response without a lookup cycle");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> !o_busy)
        else $error("lookup held for more than one cycle");

    a_ovf_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.overflow) |-> (!o_rsp.was_present && r_req.action == ACT_INSERT))
        else $error("overflow outside an insert of an absent identifier");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_req.action == ACT_CLEAR) |-> (r_row_valid == '0))
        else $error("rows still valid after clear");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for hashed_id_set_engine
// A directed table walks the bucket corner cases, then random transactions
// drawn mostly from keys aimed at a few crowded buckets hit the engine.
// Responses are checked against a shadow copy of the set or a pinned answer.
// ---------------------------------------------------------------------------
module tb_top;
    import hise_pkg::*;

    localparam int BUCKETS     = DEF_BUCKETS;
    localparam int WAYS        = DEF_WAYS;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int POOL_SIZE   = 16;
    localparam int PHASE_ITEMS = 134;
    localparam int CYCLE_LIMIT = 200000;

    localparam t_rsp RSP_MISS = '{was_present: 1'b0, overflow: 1'b0};
    localparam t_rsp RSP_HIT  = '{was_present: 1'b1, overflow: 1'b0};
    localparam t_rsp RSP_OVF  = '{was_present: 1'b0, overflow: 1'b1};

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  act;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        pin;
        t_rsp        rsp;
    } t_dir_row;

    // Keys 0/0, 1/FF, 2/FE, 3/FD and 4/FC all hash to bucket 0, one more
    // than a bucket holds. The all-ones key lands in bucket 240.
    localparam t_dir_row DIRECTED [0:23] = '{
        '{ACT_QUERY,  64'h0, 64'h0,  1'b1, RSP_MISS},
        '{ACT_QUERY,  ONES,  ONES,   1'b1, RSP_MISS},
        '{ACT_INSERT, 64'h0, 64'h0,  1'b1, RSP_MISS},
        '{ACT_INSERT, 64'h0, 64'h0,  1'b1, RSP_HIT},
        '{ACT_QUERY,  64'h0, 64'h0,  1'b0, RSP_MISS},
        '{ACT_INSERT, 64'h1, 64'hFF, 1'b0, RSP_MISS},
        '{ACT_INSERT, 64'h2, 64'hFE, 1'b0, RSP_MISS},
        '{ACT_INSERT, 64'h3, 64'hFD, 1'b0, RSP_MISS},
        '{ACT_INSERT, 64'h4, 64'hFC, 1'b1, RSP_OVF},
        '{ACT_QUERY,  64'h4, 64'hFC, 1'b0, RSP_MISS},
        '{ACT_REMOVE, 64'h1, 64'hFF, 1'b0, RSP_MISS},
        '{ACT_REMOVE, 64'h1, 64'hFF, 1'b1, RSP_MISS},
        '{ACT_INSERT, 64'h4, 64'hFC, 1'b0, RSP_MISS},
        '{ACT_QUERY,  64'h4, 64'hFC, 1'b0, RSP_MISS},
        '{ACT_INSERT, 64'h1, 64'hFF, 1'b1, RSP_OVF},
        '{ACT_INSERT, ONES,  ONES,   1'b0, RSP_MISS},
        '{ACT_QUERY,  ONES,  ONES,   1'b0, RSP_MISS},
        '{ACT_CLEAR,  ONES,  ONES,   1'b1, RSP_HIT},
        '{ACT_QUERY,  ONES,  ONES,   1'b1, RSP_MISS},
        '{ACT_QUERY,  64'h0, 64'h0,  1'b0, RSP_MISS},
        '{ACT_CLEAR,  64'h0, 64'h0,  1'b1, RSP_MISS},
        '{ACT_INSERT, ONES,  ONES,   1'b0, RSP_MISS},
        '{ACT_REMOVE, ONES,  ONES,   1'b0, RSP_MISS},
        '{ACT_REMOVE, 64'h0, 64'h0,  1'b0, RSP_MISS}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    // Pinned expectation that travels with the request being offered.
    logic row_pin;
    t_rsp row_rsp;

    bit          shadow_valid [SLOTS];
    logic [63:0] shadow_lo [SLOTS];
    logic [63:0] shadow_hi [SLOTS];
    t_rsp        answers_due [$];
    logic [63:0] pool_lo [POOL_SIZE];
    logic [63:0] pool_hi [POOL_SIZE];
    int          sender_idle_pct;
    int          mismatches;
    int          cycle_count;

    hashed_id_set_engine #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Applies one transaction to the shadow set and returns its answer.
    function automatic t_rsp apply_to_shadow_set(input t_req r);
        int unsigned sum;
        int unsigned base;
        int          hit;
        int          free_way;
        t_rsp        rsp;
        sum = 0;
        for (int b = 0; b < 8; b++) begin
            sum += r.key_low[8*b +: 8];
            sum += r.key_high[8*b +: 8];
        end
        base     = ((sum & 8'hFF) % BUCKETS) * WAYS;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (shadow_valid[base + w]) begin
                if (hit < 0 && shadow_lo[base + w] == r.key_low
                        && shadow_hi[base + w] == r.key_high) begin
                    hit = w;
                end
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        rsp.was_present = (hit >= 0);
        rsp.overflow    = 1'b0;
        case (r.action)
            ACT_INSERT: begin
                if (hit < 0) begin
                    if (free_way >= 0) begin
                        shadow_valid[base + free_way] = 1'b1;
                        shadow_lo[base + free_way]    = r.key_low;
                        shadow_hi[base + free_way]    = r.key_high;
                    end else begin
                        rsp.overflow = 1'b1;
                    end
                end
            end
            ACT_REMOVE: begin
                if (hit >= 0) begin
                    shadow_valid[base + hit] = 1'b0;
                end
            end
            ACT_CLEAR: begin
                for (int s = 0; s < SLOTS; s++) begin
                    shadow_valid[s] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Responses are matched first, then a request taken at this edge is
    // predicted, so ordering within the time step cannot matter.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("response with no transaction outstanding");
                end else begin
                    want = answers_due.pop_front();
                    if (o_rsp.was_present !== want.was_present) begin
                        report_mismatch($sformatf("was_present got %b expected %b",
                                                  o_rsp.was_present, want.was_present));
                    end
                    if (o_rsp.overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow got %b expected %b",
                                                  o_rsp.overflow, want.overflow));
                    end
                end
            end
            if (i_start && !o_busy) begin
                want = apply_to_shadow_set(i_req);
                if (row_pin) begin
                    want = row_rsp;
                end
                answers_due.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("** hashed_id_set_engine: FAILED **");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic issue(input t_req r, input logic pin, input t_rsp pinned);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_start <= 1'b1;
        i_req   <= r;
        row_pin <= pin;
        row_rsp <= pinned;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic wait_for_answers();
        i_start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
    endtask

    // Key with random content whose bytes sum to the wanted bucket.
    task automatic make_key(input int unsigned bucket, output logic [63:0] lo,
                            output logic [63:0] hi);
        int unsigned sum;
        lo  = {$urandom, $urandom};
        hi  = {$urandom, $urandom};
        sum = 0;
        for (int b = 0; b < 8; b++) begin
            sum += lo[8*b +: 8];
        end
        for (int b = 0; b < 7; b++) begin
            sum += hi[8*b +: 8];
        end
        hi[63:56] = 8'(bucket - sum);
    endtask

    // Six keys for each of two crowded buckets and a few strays.
    task automatic refill_pool();
        int unsigned hot_a;
        int unsigned hot_b;
        hot_a = $urandom_range(BUCKETS - 1);
        hot_b = $urandom_range(BUCKETS - 1);
        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k < 6) begin
                make_key(hot_a, pool_lo[k], pool_hi[k]);
            end else if (k < 12) begin
                make_key(hot_b, pool_lo[k], pool_hi[k]);
            end else begin
                pool_lo[k] = {$urandom, $urandom};
                pool_hi[k] = {$urandom, $urandom};
            end
        end
    endtask

    function automatic t_req random_request();
        t_req        r;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(99);
        if (roll < 3) begin
            r.action = ACT_CLEAR;
        end else if (roll < 43) begin
            r.action = ACT_INSERT;
        end else if (roll < 68) begin
            r.action = ACT_QUERY;
        end else begin
            r.action = ACT_REMOVE;
        end
        if ($urandom_range(99) < 85) begin
            pick       = $urandom_range(POOL_SIZE - 1);
            r.key_low  = pool_lo[pick];
            r.key_high = pool_hi[pick];
        end else begin
            r.key_low  = {$urandom, $urandom};
            r.key_high = {$urandom, $urandom};
        end
        return r;
    endfunction

    initial begin
        t_req r;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_req           = '0;
        row_pin         = 1'b0;
        row_rsp         = RSP_MISS;
        mismatches      = 0;
        cycle_count     = 0;
        sender_idle_pct = 30;
        for (int s = 0; s < SLOTS; s++) begin
            shadow_valid[s] = 1'b0;
            shadow_lo[s]    = '0;
            shadow_hi[s]    = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < $size(DIRECTED); n++) begin
            r.action   = DIRECTED[n].act;
            r.key_low  = DIRECTED[n].lo;
            r.key_high = DIRECTED[n].hi;
            issue(r, DIRECTED[n].pin, DIRECTED[n].rsp);
        end
        // Let the engine drain completely before the random traffic starts.
        wait_for_answers();

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 81 : 0;
            refill_pool();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue(random_request(), 1'b0, RSP_MISS);
            end
            wait_for_answers();
        end

        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** hashed_id_set_engine: PASSED **");
        end else begin
            $display("** hashed_id_set_engine: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hise_pkg.sv
rtl/hise_hash.sv
rtl/hise_row_mem.sv
rtl/hise_match.sv
rtl/hashed_id_set_engine.sv
tb/tb_top.sv
